@@ rtl/core/dgtm_pkg.sv @@
package dgtm_pkg;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int VID_W      = 19;
    localparam int DIM_W      = 10;
    localparam int THR_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_THR  = CFG_IDX_W'(2);

    // Register reset values
    localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(480);
    localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(512);
    localparam logic [THR_W-1:0] THR_RST  = THR_W'(6554);

    // Grid size defaults
    localparam int MAX_ROWS_DEF = 512;
    localparam int MAX_COLS_DEF = 512;

    // Vertex numbering
    localparam logic [VID_W-1:0] VID_FIRST = VID_W'(1);
    localparam logic [VID_W-1:0] VID_MAX   = '1;

    // Job queue between classifier and record emitter
    localparam int JOBQ_DEPTH = 4;

    // Cell corner codes
    localparam logic [1:0] C00 = 2'd0;
    localparam logic [1:0] C10 = 2'd1;
    localparam logic [1:0] C01 = 2'd2;
    localparam logic [1:0] C11 = 2'd3;

    // Record kinds
    localparam logic KIND_VERT = 1'b0;
    localparam logic KIND_FACE = 1'b1;

    // Record slots of one job: three vertex slots then the face, twice
    localparam int REC_SLOTS = 8;

    typedef logic [2:0][1:0] sel_t;

    // Second triangle of a cell is always 00, 10, 11
    localparam sel_t F1_SEL = {C11, C10, C00};

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } pt_t;

    typedef struct packed {
        logic [REC_SLOTS-1:0]      mask;
        sel_t                      sel0;
        logic [3:0][VID_W-1:0]     ids;
        pt_t  [3:0]                pts;
    } job_t;

    typedef struct packed {
        logic               kind;
        logic [VID_W-1:0]   vert_index;
        logic [COORD_W-1:0] vert_x;
        logic [COORD_W-1:0] vert_y;
        logic [COORD_W-1:0] vert_z;
        logic [VID_W-1:0]   corner_a;
        logic [VID_W-1:0]   corner_b;
        logic [VID_W-1:0]   corner_c;
        logic               last;
    } rec_t;

    // |za - zb| < thr, exact on signed Q16.16 depths
    function automatic logic near_depth(input logic [COORD_W-1:0] za,
                                        input logic [COORD_W-1:0] zb,
                                        input logic [THR_W-1:0]   thr);
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {za[COORD_W-1], za} - {zb[COORD_W-1], zb};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m < (COORD_W+1)'(thr);
    endfunction

endpackage

@@ rtl/core/dgtm_ram.sv @@
module dgtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/dgtm_front.sv @@
module dgtm_front
    import dgtm_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] pt_x,
    input  logic signed [COORD_W-1:0] pt_y,
    input  logic signed [COORD_W-1:0] pt_z,
    output logic                      job_valid,
    input  logic                      job_ready,
    output job_t                      job
);

    localparam int RIDX_W = $clog2(MAX_ROWS);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CIDX_W = $clog2(MAX_COLS);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int RAM_W  = $bits(pt_t) + VID_W;

    // Configuration
    logic [DIM_W-1:0] grid_rows_reg;
    logic [DIM_W-1:0] grid_cols_reg;
    logic [THR_W-1:0] thr_reg;
    logic             restart;

    // Grid position
    logic [RIDX_W-1:0] row_reg;
    logic [CIDX_W-1:0] col_reg;
    logic [RCNT_W-1:0] rows_eff;
    logic [CCNT_W-1:0] cols_eff;
    logic              last_row;
    logic              last_col;
    logic              accept;

    // Stage 1: point captured, column store read in flight
    logic              s1_valid_reg;
    pt_t               s1_pt_reg;
    logic [RIDX_W-1:0] s1_row_reg;
    logic              s1_cell_reg;
    logic              s1_fend_reg;
    logic              byp_reg;
    logic [RAM_W-1:0]  byp_data_reg;

    // Stage 2: triangles chosen, indices assigned
    logic              s2_valid_reg;
    pt_t [3:0]         s2_pts_reg;
    logic [VID_W-1:0]  s2_id10_reg;
    logic              s2_f0en_reg;
    logic              s2_f1en_reg;
    sel_t              s2_sel0_reg;
    logic [RIDX_W-1:0] s2_row_reg;
    logic              s2_fend_reg;
    logic              s2_go;
    logic              need_push;

    // Running neighbor state
    pt_t               p00_reg;
    pt_t               above_pt_reg;
    logic [VID_W-1:0]  id00_reg;
    logic [VID_W-1:0]  above_id_reg;
    logic [VID_W-1:0]  nvid_reg;
    logic [RIDX_W-1:0] wr_row_reg;

    // Column store
    logic              ram_we;
    logic [RAM_W-1:0]  ram_wdata;
    logic [RAM_W-1:0]  ram_rdata;
    logic [RAM_W-1:0]  rd_word;
    pt_t               rd_pt;
    logic [VID_W-1:0]  rd_id;

    // Stage 1 decisions
    logic              f0en;
    logic              f1en;
    sel_t              sel0;

    // Stage 2 results
    logic [3:0][VID_W-1:0] fin_ids;
    logic [VID_W-1:0]      nv_out;
    logic [5:0]            newf;

    // Clamp geometry
    always_comb
    begin
        if (grid_rows_reg < DIM_W'(2))
        begin
            rows_eff = RCNT_W'(2);
        end
        else if (32'(grid_rows_reg) > MAX_ROWS)
        begin
            rows_eff = RCNT_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RCNT_W'(grid_rows_reg);
        end
        if (grid_cols_reg < DIM_W'(2))
        begin
            cols_eff = CCNT_W'(2);
        end
        else if (32'(grid_cols_reg) > MAX_COLS)
        begin
            cols_eff = CCNT_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = CCNT_W'(grid_cols_reg);
        end
    end

    assign last_row = (RCNT_W'(row_reg) + RCNT_W'(1)) >= rows_eff;
    assign last_col = (CCNT_W'(col_reg) + CCNT_W'(1)) >= cols_eff;
    assign restart  = cfg_we && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS));

    // A new point may enter once the previous one has left stage 2
    assign in_ready = !s1_valid_reg && (!s2_valid_reg || s2_go);
    assign accept   = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= ROWS_RST;
            grid_cols_reg <= COLS_RST;
            thr_reg       <= THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS: grid_rows_reg <= cfg_data[DIM_W-1:0];
                REG_COLS: grid_cols_reg <= cfg_data[DIM_W-1:0];
                REG_THR:  thr_reg       <= cfg_data[THR_W-1:0];
                default:  ;
            endcase
        end
    end

    // Row and column counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (restart)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (last_row)
            begin
                row_reg <= '0;
                col_reg <= last_col ? '0 : col_reg + CIDX_W'(1);
            end
            else
            begin
                row_reg <= row_reg + RIDX_W'(1);
            end
        end
    end

    // Column store: one entry per row, point plus its vertex index
    assign ram_we    = s2_go;
    assign ram_wdata = {s2_pts_reg[C01], fin_ids[C01]};

    dgtm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_row_reg),
        .wdata (ram_wdata),
        .raddr (row_reg),
        .rdata (ram_rdata)
    );

    // Stage 1 valid and stage 2 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1 capture, with forwarding of a same-cycle store write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pt_reg    <= '{x: $unsigned(pt_x), y: $unsigned(pt_y), z: $unsigned(pt_z)};
            s1_row_reg   <= row_reg;
            s1_cell_reg  <= (row_reg != '0) && (col_reg != '0);
            s1_fend_reg  <= last_row && last_col;
            byp_reg      <= ram_we && (wr_row_reg == row_reg);
            byp_data_reg <= ram_wdata;
        end
    end

    assign rd_word = byp_reg ? byp_data_reg : ram_rdata;
    assign rd_pt   = rd_word[RAM_W-1:VID_W];
    assign rd_id   = rd_word[VID_W-1:0];

    // Triangle choice and depth tests
    always_comb
    begin
        logic z00;
        logic z10;
        logic z01;
        logic z11;
        logic n01_10;
        logic n11_10;
        logic n01_11;
        logic n00_01;
        logic n10_00;
        logic n00_11;
        z00    = (p00_reg.z == '0);
        z10    = (rd_pt.z == '0);
        z01    = (above_pt_reg.z == '0);
        z11    = (s1_pt_reg.z == '0);
        n01_10 = near_depth(above_pt_reg.z, rd_pt.z, thr_reg);
        n11_10 = near_depth(s1_pt_reg.z, rd_pt.z, thr_reg);
        n01_11 = near_depth(above_pt_reg.z, s1_pt_reg.z, thr_reg);
        n00_01 = near_depth(p00_reg.z, above_pt_reg.z, thr_reg);
        n10_00 = near_depth(rd_pt.z, p00_reg.z, thr_reg);
        n00_11 = near_depth(p00_reg.z, s1_pt_reg.z, thr_reg);
        f0en   = 1'b0;
        f1en   = 1'b0;
        sel0   = {C11, C01, C00};
        priority if (!s1_cell_reg)
        begin
            f0en = 1'b0;
        end
        else if (z00)
        begin
            // top-left missing: triangle on the other three corners
            sel0 = {C11, C10, C01};
            f0en = !z01 && !z10 && !z11 && n01_10 && n11_10 && n01_11;
        end
        else if (z11)
        begin
            // bottom-right missing: triangle on the first three corners
            sel0 = {C10, C01, C00};
            f0en = !z01 && !z10 && n00_01 && n01_10 && n10_00;
        end
        else
        begin
            sel0 = {C11, C01, C00};
            f0en = !z01 && n00_01 && n01_11 && n00_11;
            f1en = !z10 && n00_11 && n11_10 && n10_00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_pts_reg[C00] <= p00_reg;
            s2_pts_reg[C10] <= rd_pt;
            s2_pts_reg[C01] <= above_pt_reg;
            s2_pts_reg[C11] <= s1_pt_reg;
            s2_id10_reg     <= rd_id;
            s2_f0en_reg     <= f0en;
            s2_f1en_reg     <= f1en;
            s2_sel0_reg     <= sel0;
            s2_row_reg      <= s1_row_reg;
            s2_fend_reg     <= s1_fend_reg;
        end
    end

    // Vertex numbering in record order
    always_comb
    begin
        logic [3:0][VID_W-1:0] cid;
        logic [VID_W-1:0]      nv;
        logic [1:0]            c;
        logic                  en;
        cid[C00] = id00_reg;
        cid[C10] = s2_id10_reg;
        cid[C01] = above_id_reg;
        cid[C11] = '0;
        nv       = nvid_reg;
        newf     = '0;
        for (int s = 0; s < 6; s++)
        begin
            if (s < 3)
            begin
                en = s2_f0en_reg;
                c  = s2_sel0_reg[s];
            end
            else
            begin
                en = s2_f1en_reg;
                c  = F1_SEL[s-3];
            end
            if (en && (cid[c] == '0))
            begin
                cid[c]  = nv;
                newf[s] = 1'b1;
                if (nv != VID_MAX)
                begin
                    nv = nv + VID_W'(1);
                end
            end
        end
        fin_ids = cid;
        nv_out  = nv;
    end

    assign need_push = s2_f0en_reg || s2_f1en_reg;
    assign s2_go     = s2_valid_reg && (!need_push || job_ready);
    assign job_valid = s2_valid_reg && need_push;

    assign job.mask = {s2_f1en_reg, newf[5:3], s2_f0en_reg, newf[2:0]};
    assign job.sel0 = s2_sel0_reg;
    assign job.ids  = fin_ids;
    assign job.pts  = s2_pts_reg;

    // Neighbor state update as an item leaves stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nvid_reg     <= VID_FIRST;
            wr_row_reg   <= '0;
            id00_reg     <= '0;
            above_id_reg <= '0;
        end
        else if (restart)
        begin
            nvid_reg <= VID_FIRST;
        end
        else if (s2_go)
        begin
            nvid_reg     <= s2_fend_reg ? VID_FIRST : nv_out;
            wr_row_reg   <= s2_row_reg;
            id00_reg     <= fin_ids[C10];
            above_id_reg <= fin_ids[C11];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            p00_reg      <= s2_pts_reg[C10];
            above_pt_reg <= s2_pts_reg[C11];
        end
    end

endmodule

@@ rtl/core/dgtm_jobq.sv @@
module dgtm_jobq
    import dgtm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    job_t              slots [JOBQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(JOBQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/dgtm_back.sv @@
module dgtm_back
    import dgtm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    output logic out_valid,
    input  logic out_ready,
    output rec_t rec
);

    job_t                 cur_job_reg;
    logic [REC_SLOTS-1:0] cur_mask_reg;
    logic                 out_valid_reg;
    rec_t                 rec_reg;

    logic                 has_rec;
    logic                 load_ok;
    logic                 emit;
    logic                 take_job;
    logic [2:0]           idx;
    logic [REC_SLOTS-1:0] rem;
    rec_t                 rec_next;

    // Lowest pending record slot
    always_comb
    begin
        idx = '0;
        for (int i = REC_SLOTS - 1; i >= 0; i--)
        begin
            if (cur_mask_reg[i])
            begin
                idx = 3'(i);
            end
        end
    end

    assign rem      = cur_mask_reg & ~(REC_SLOTS'(1) << idx);
    assign has_rec  = (cur_mask_reg != '0);
    assign load_ok  = !out_valid_reg || out_ready;
    assign emit     = has_rec && load_ok;
    assign take_job = job_valid && (!has_rec || (emit && (rem == '0)));
    assign job_ready = take_job;

    // Build the record for the chosen slot
    always_comb
    begin
        sel_t       fsel;
        logic [1:0] corner;
        fsel     = idx[2] ? F1_SEL : cur_job_reg.sel0;
        corner   = C00;
        rec_next = '0;
        rec_next.last = (rem == '0);
        if (idx[1:0] == 2'd3)
        begin
            rec_next.kind     = KIND_FACE;
            rec_next.corner_a = cur_job_reg.ids[fsel[0]];
            rec_next.corner_b = cur_job_reg.ids[fsel[1]];
            rec_next.corner_c = cur_job_reg.ids[fsel[2]];
        end
        else
        begin
            corner              = fsel[idx[1:0]];
            rec_next.kind       = KIND_VERT;
            rec_next.vert_index = cur_job_reg.ids[corner];
            rec_next.vert_x     = cur_job_reg.pts[corner].x;
            rec_next.vert_y     = cur_job_reg.pts[corner].y;
            rec_next.vert_z     = cur_job_reg.pts[corner].z;
        end
    end

    // Pending slots and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_job)
            begin
                cur_mask_reg <= job.mask;
            end
            else if (emit)
            begin
                cur_mask_reg <= rem;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_job)
        begin
            cur_job_reg <= job;
        end
        if (emit)
        begin
            rec_reg <= rec_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign rec       = rec_reg;

endmodule

@@ rtl/core/depth_grid_triangle_mesher_core.sv @@
// Depth grid triangle mesher.
// Input channel (in_valid/in_ready, pt_x/pt_y/pt_z): grid points in Q16.16,
// column by column, rows 0..grid_rows-1 in each column. A zero depth marks
// a missing point. Output channel (out_valid/out_ready): mesh records, a new
// vertex record (kind 0) ahead of each face (kind 1) that first uses it;
// last marks the final record caused by one point. A point causes 0 to 6
// records.
// A new point is not accepted while the previous one is in stage 1, waiting
// for the column store read that its cell needs before it can be classified;
// records leave at one per cycle while the receiver takes them.
// A 4-entry job queue lets the classifier run ahead of the record emitter.
// When the receiver stalls, the emitter holds its record; the queue fills
// and then in_ready drops until a slot frees.
// Reset returns the registers to 480 rows, 512 columns, threshold 6554, and
// starts a frame at row 0, column 0 with vertex index 1. Writing grid_rows
// or grid_cols also restarts the frame; write only while idle.
module depth_grid_triangle_mesher_core
    import dgtm_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] pt_x,
    input  logic signed [COORD_W-1:0] pt_y,
    input  logic signed [COORD_W-1:0] pt_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      kind,
    output logic [VID_W-1:0]          vert_index,
    output logic signed [COORD_W-1:0] vert_x,
    output logic signed [COORD_W-1:0] vert_y,
    output logic signed [COORD_W-1:0] vert_z,
    output logic [VID_W-1:0]          corner_a,
    output logic [VID_W-1:0]          corner_b,
    output logic [VID_W-1:0]          corner_c,
    output logic                      last
);

    logic fq_valid;
    logic fq_ready;
    job_t fq_job;
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;
    rec_t rec;

    // Classifier and vertex numbering
    dgtm_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pt_x      (pt_x),
        .pt_y      (pt_y),
        .pt_z      (pt_z),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // Job queue
    dgtm_jobq u_jobq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    // Record emitter
    dgtm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rec       (rec)
    );

    assign kind       = rec.kind;
    assign vert_index = rec.vert_index;
    assign vert_x     = $signed(rec.vert_x);
    assign vert_y     = $signed(rec.vert_y);
    assign vert_z     = $signed(rec.vert_z);
    assign corner_a   = rec.corner_a;
    assign corner_b   = rec.corner_b;
    assign corner_c   = rec.corner_c;
    assign last       = rec.last;

endmodule

@@ rtl/core/dgtm_checker.sv @@
module dgtm_checker
    import dgtm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      kind,
    input logic [VID_W-1:0]          vert_index,
    input logic signed [COORD_W-1:0] vert_x,
    input logic signed [COORD_W-1:0] vert_y,
    input logic signed [COORD_W-1:0] vert_z,
    input logic [VID_W-1:0]          corner_a,
    input logic [VID_W-1:0]          corner_b,
    input logic [VID_W-1:0]          corner_c,
    input logic                      last
);

    // A stalled record holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(vert_index)
            && $stable(vert_x) && $stable(vert_y) && $stable(vert_z)
            && $stable(corner_a) && $stable(corner_b) && $stable(corner_c) && $stable(last))
        else $error("stalled record changed");

    // in_ready drops after each point transfer
    a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("point transfer in back-to-back cycles");

    // A vertex record always precedes its face, so it never closes a point
    a_vert_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_VERT) |-> !last && (vert_index != '0))
        else $error("bad vertex record");

    // A face refers to numbered vertices only
    a_face_ids: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_FACE) |-> (vert_index == '0) && (corner_a != '0)
            && (corner_b != '0) && (corner_c != '0) && last == last)
        else $error("face with unnumbered corner");

endmodule

bind depth_grid_triangle_mesher_core dgtm_checker u_dgtm_checker (.*);
